// ===== rtl/core/neighbor_conflict_wait_queue_defines.svh =====
// Assertion macros for the wait queue.
`ifndef NEIGHBOR_CONFLICT_WAIT_QUEUE_DEFINES_SVH
`define NEIGHBOR_CONFLICT_WAIT_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
`define NCWQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NCWQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NCWQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define NCWQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/ncwq_pkg.sv =====
package ncwq_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int ID_BITS     = 8;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int STATUS_W    = 3;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_PARTNER = 3'd4;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_NEXT   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [ID_BITS-1:0] left;
        logic [ID_BITS-1:0] right;
    } entry_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/ncwq_cell.sv =====
module ncwq_cell (
    input  logic                         clk,
    input  ncwq_pkg::cell_ctrl_t         ctrl,
    input  ncwq_pkg::entry_t             wr_data,
    input  ncwq_pkg::entry_t             nbr_data,
    input  logic [ncwq_pkg::ID_BITS-1:0] cmp_a,
    input  logic [ncwq_pkg::ID_BITS-1:0] cmp_b,
    output ncwq_pkg::entry_t             data,
    output logic                         hit
);
    import ncwq_pkg::*;

    entry_t data_reg;
    entry_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = wr_data;
        end
        else if (ctrl.shift)
        begin
            data_next = nbr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign hit  = (data_reg.id == cmp_a) || (data_reg.id == cmp_b);

endmodule

// ===== rtl/core/neighbor_conflict_wait_queue.sv =====
// Ordered wait list of up to MAX_ENTRIES requesters held in a row of cells, each cell one
// entry (id, left and right neighbor). One transaction in gives one transaction out with
// status, result id and the entry count after the request. Add and the unused request type
// go from acceptance through the scan state, the done state and the output register; remove
// and get-next walk the row one cell per cycle from the front, visiting at most count cells.
// Each get-next step compares every cell's id against the visited entry's neighbors at once,
// each remove step against the requested id. A new transaction is taken once the previous
// result is in the output register.
`include "neighbor_conflict_wait_queue_defines.svh"

module neighbor_conflict_wait_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [ncwq_pkg::ID_BITS-1:0]  entry_id,
    input  logic [ncwq_pkg::ID_BITS-1:0]  left_id,
    input  logic [ncwq_pkg::ID_BITS-1:0]  right_id,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ncwq_pkg::STATUS_W-1:0] status,
    output logic [ncwq_pkg::ID_BITS-1:0]  result_id,
    output logic [ncwq_pkg::CNT_W-1:0]    entry_count
);
    import ncwq_pkg::*;

    state_t              state_reg, state_next;
    req_t                req_reg;
    logic [ID_BITS-1:0]  id_reg, left_reg, right_reg;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ID_BITS-1:0]  res_id_reg, res_id_next;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ID_BITS-1:0]  out_result_reg;
    logic [CNT_W-1:0]    out_count_reg;

    logic                   accept;
    logic                   add_go, rem_go, out_load;
    entry_t                 cell_q [MAX_ENTRIES];
    cell_ctrl_t             ctrl   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] hit;
    logic [MAX_ENTRIES-1:0] le_mask;
    entry_t                 cur;
    entry_t                 wr_entry;
    logic [ID_BITS-1:0]     cmp_a, cmp_b;
    logic                   last_k, clash;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    assign cur      = cell_q[k_reg];
    assign wr_entry = '{id: id_reg, left: left_reg, right: right_reg};
    assign cmp_a    = (req_reg == REQ_REMOVE) ? id_reg : cur.left;
    assign cmp_b    = (req_reg == REQ_REMOVE) ? id_reg : cur.right;
    assign last_k   = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
    assign clash    = |(hit & le_mask);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            assign le_mask[gi]    = (IDX_W'(gi) <= k_reg);
            assign ctrl[gi].load  = add_go && (count_reg == CNT_W'(gi));
            assign ctrl[gi].shift = rem_go && (IDX_W'(gi) >= k_reg);

            ncwq_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl[gi]),
                .wr_data  (wr_entry),
                .nbr_data ((gi == MAX_ENTRIES - 1) ? cell_q[gi] : cell_q[(gi + 1) % MAX_ENTRIES]),
                .cmp_a    (cmp_a),
                .cmp_b    (cmp_b),
                .data     (cell_q[gi]),
                .hit      (hit[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        add_go          = 1'b0;
        rem_go          = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                k_next = '0;
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                res_id_next = '0;
                case (req_reg)
                    REQ_ADD:
                    begin
                        state_next = S_DONE;
                        if (count_reg >= CNT_W'(MAX_ENTRIES))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            add_go          = 1'b1;
                            count_next      = count_reg + CNT_W'(1);
                            res_status_next = ST_OK;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else if (hit[k_reg])
                        begin
                            rem_go          = 1'b1;
                            count_next      = count_reg - CNT_W'(1);
                            res_status_next = ST_OK;
                            res_id_next     = id_reg;
                            state_next      = S_DONE;
                        end
                        else if (last_k)
                        begin
                            res_status_next = ST_NOT_FOUND;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            k_next = k_reg + IDX_W'(1);
                        end
                    end
                    REQ_NEXT:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_NO_PARTNER;
                            state_next      = S_DONE;
                        end
                        else if (cur.id != left_reg && cur.id != right_reg && !clash)
                        begin
                            res_status_next = ST_OK;
                            res_id_next     = cur.id;
                            state_next      = S_DONE;
                        end
                        else if (last_k)
                        begin
                            res_status_next = ST_NO_PARTNER;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            k_next = k_reg + IDX_W'(1);
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                        state_next      = S_DONE;
                    end
                endcase
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        if (accept)
        begin
            req_reg   <= req_t'(req_type);
            id_reg    <= entry_id;
            left_reg  <= left_id;
            right_reg <= right_id;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_result_reg <= res_id_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign result_id   = out_result_reg;
    assign entry_count = out_count_reg;

    `NCWQ_ASSERT_ALWAYS(a_count_range, clk, count_reg <= CNT_W'(MAX_ENTRIES), "count exceeds depth")
    `NCWQ_ASSERT(a_accept_scan, clk, rst_n, accept |=> state_reg == S_SCAN, "accept did not start scan")
    `NCWQ_ASSERT(a_done_out, clk, rst_n, (state_reg == S_DONE && !(out_valid && out_stall)) |=> out_valid, "result not loaded")
    `NCWQ_ASSERT(a_add_count, clk, rst_n, add_go |=> count_reg == $past(count_reg) + CNT_W'(1), "add did not grow count")

endmodule
